/* design/unsigned_divide_64_by_32_defines.svh */
`ifndef UNSIGNED_DIVIDE_64_BY_32_DEFINES_SVH
`define UNSIGNED_DIVIDE_64_BY_32_DEFINES_SVH

// same-cycle implication, ignored while reset is low
`define UDIV_ASSERT_NOW(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("udiv: same-cycle check failed");

// next-cycle implication, ignored while reset is low
`define UDIV_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("udiv: next-cycle check failed");

`endif

/* design/udiv_pkg.sv */
`default_nettype none

package udiv_pkg;

    localparam int DIVIDEND_W = 64;
    localparam int DIVISOR_W  = 32;
    localparam int QUOT_W     = 32;
    localparam int NUM_STEPS  = 32;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_DIVZERO  = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [DIVISOR_W-1:0] rem;
        logic [QUOT_W-1:0]    bits;
        logic [DIVISOR_W-1:0] divisor;
        status_t              status;
    } step_data_t;

endpackage

`default_nettype wire

/* design/udiv_stage.sv */
`default_nettype none

module udiv_stage
    import udiv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire step_data_t in_data,
    output logic            in_stall,
    output logic            out_valid,
    output step_data_t      out_data,
    input  wire logic       out_stall
);

    logic                 valid_reg;
    step_data_t           data_reg;
    step_data_t           data_next;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W+1:0] diff;
    logic                 take;

    always_comb
    begin
        trial = {in_data.rem, in_data.bits[QUOT_W-1]};
        diff  = {1'b0, trial} - {2'b00, in_data.divisor};
        take  = ~diff[DIVISOR_W+1];
        data_next         = in_data;
        data_next.rem     = take ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        data_next.bits    = {in_data.bits[QUOT_W-2:0], take};
    end

    assign in_stall  = valid_reg & out_stall;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    // hold payload unless a new beat moves in
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* design/unsigned_divide_64_by_32.sv */
// Each accepted input beat passes through one check stage, 32 one-bit subtract
// stages and one output register, in that order, before it leaves as an output beat.
// Throughput: one beat per cycle while the output does not stall; empty stages fill while it stalls.
// Reset: rst_n clears all valid bits asynchronously; payload is not reset.
`default_nettype none

`include "unsigned_divide_64_by_32_defines.svh"

module unsigned_divide_64_by_32
    import udiv_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [QUOT_W-1:0]          quotient,
    output logic [1:0]                 status
);

    logic        entry_valid_reg;
    step_data_t  entry_data_reg;
    step_data_t  entry_next;
    logic        entry_stall;

    logic        link_valid [0:NUM_STEPS];
    step_data_t  link_data  [0:NUM_STEPS];
    logic        link_stall [0:NUM_STEPS];

    logic              out_valid_reg;
    logic [QUOT_W-1:0] quotient_reg;
    status_t           status_reg;

    always_comb
    begin
        entry_next.rem     = dividend[DIVIDEND_W-1:DIVIDEND_W-DIVISOR_W];
        entry_next.bits    = dividend[QUOT_W-1:0];
        entry_next.divisor = divisor;
        priority if (divisor == '0)
        begin
            entry_next.status = STATUS_DIVZERO;
        end
        else if (dividend[DIVIDEND_W-1:DIVIDEND_W-DIVISOR_W] >= divisor)
        begin
            entry_next.status = STATUS_OVERFLOW;
        end
        else
        begin
            entry_next.status = STATUS_OK;
        end
    end

    assign entry_stall = entry_valid_reg & link_stall[0];
    assign in_stall    = entry_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
        end
        else if (!entry_stall)
        begin
            entry_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!entry_stall && in_valid)
        begin
            entry_data_reg <= entry_next;
        end
    end

    assign link_valid[0] = entry_valid_reg;
    assign link_data[0]  = entry_data_reg;

    genvar g;
    for (g = 0; g < NUM_STEPS; g++)
    begin : g_step
        udiv_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[g]),
            .in_data   (link_data[g]),
            .in_stall  (link_stall[g]),
            .out_valid (link_valid[g+1]),
            .out_data  (link_data[g+1]),
            .out_stall (link_stall[g+1])
        );
    end

    assign link_stall[NUM_STEPS] = out_valid_reg & out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!link_stall[NUM_STEPS])
        begin
            out_valid_reg <= link_valid[NUM_STEPS];
        end
    end

    // drop the quotient on any error
    always_ff @(posedge clk)
    begin
        if (!link_stall[NUM_STEPS] && link_valid[NUM_STEPS])
        begin
            quotient_reg <= (link_data[NUM_STEPS].status == STATUS_OK) ?
                            link_data[NUM_STEPS].bits : '0;
            status_reg   <= link_data[NUM_STEPS].status;
        end
    end

    assign out_valid = out_valid_reg;
    assign quotient  = quotient_reg;
    assign status    = status_reg;

    `UDIV_ASSERT_NOW(a_error_zero_quotient, clk, rst_n,
        out_valid_reg && status_reg != STATUS_OK, quotient_reg == '0)
    `UDIV_ASSERT_NEXT(a_divzero_flagged, clk, rst_n,
        in_valid && !in_stall && divisor == '0,
        entry_valid_reg && entry_data_reg.status == STATUS_DIVZERO)
    `UDIV_ASSERT_NEXT(a_entry_held, clk, rst_n,
        entry_valid_reg && link_stall[0], entry_valid_reg)

endmodule

`default_nettype wire

/* verif/udiv_result_checker.sv */
module udiv_result_checker
    import udiv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [QUOT_W-1:0]     quotient,
    input  logic [1:0]            status,
    output int                    mismatches,
    output int                    outstanding,
    output int                    checked,
    output int                    zero_divides,
    output int                    overflows
);

    typedef struct packed {
        logic [QUOT_W-1:0] quot;
        status_t           st;
    } division_result_t;

    division_result_t awaited_results[$];

    initial
    begin
        mismatches   = 0;
        outstanding  = 0;
        checked      = 0;
        zero_divides = 0;
        overflows    = 0;
    end

    function automatic division_result_t predict_division(
        input logic [DIVIDEND_W-1:0] num,
        input logic [DIVISOR_W-1:0]  den
    );
        division_result_t r;
        logic [DIVIDEND_W-1:0] full_quot;
        r.quot = '0;
        if (den == '0)
        begin
            r.st = STATUS_DIVZERO;
        end
        else if (num[DIVIDEND_W-1:DIVISOR_W] >= den)
        begin
            r.st = STATUS_OVERFLOW;
        end
        else
        begin
            full_quot = num / {{(DIVIDEND_W-DIVISOR_W){1'b0}}, den};
            r.st   = STATUS_OK;
            r.quot = full_quot[QUOT_W-1:0];
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        division_result_t want;
        if (!rst_n)
        begin
            awaited_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                awaited_results.push_back(predict_division(dividend, divisor));
            if (out_valid && !out_stall)
            begin
                checked++;
                if (status == STATUS_DIVZERO)
                    zero_divides++;
                if (status == STATUS_OVERFLOW)
                    overflows++;
                if (awaited_results.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected beat quot=%h st=%0d",
                                            quotient, status));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (quotient !== want.quot)
                        flag_mismatch($sformatf("quotient got %h want %h",
                                                quotient, want.quot));
                    if (status !== want.st)
                        flag_mismatch($sformatf("st got %0d want %0d",
                                                status, want.st));
                end
            end
            outstanding <= awaited_results.size();
        end
    end

endmodule

/* verif/testbench.sv */
module testbench;
    import udiv_pkg::*;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [DIVIDEND_W-1:0] dividend  = '0;
    logic [DIVISOR_W-1:0]  divisor   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [QUOT_W-1:0]     quotient;
    logic [1:0]            status;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int sent          = 0;
    int directed      = 0;
    int mismatches;
    int outstanding;
    int checked;
    int zero_divides;
    int overflows;

    unsigned_divide_64_by_32 i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .dividend  (dividend),
        .divisor   (divisor),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .quotient  (quotient),
        .status    (status)
    );

    udiv_result_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .dividend     (dividend),
        .divisor      (divisor),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .quotient     (quotient),
        .status       (status),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .checked      (checked),
        .zero_divides (zero_divides),
        .overflows    (overflows)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    task automatic send_division(input logic [DIVIDEND_W-1:0] num,
                                 input logic [DIVISOR_W-1:0]  den);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            dividend <= {$urandom, $urandom};
            divisor  <= $urandom;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        dividend <= num;
        divisor  <= den;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    // hold off the sender until every beat in flight has come back
    task automatic drain_divider();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic send_random_division();
        logic [DIVISOR_W-1:0] den;
        logic [DIVISOR_W-1:0] hi;
        logic [DIVISOR_W-1:0] lo;
        int kind;
        case ($urandom_range(7))
            0: den = $urandom_range(255, 1);
            1: den = {1'b1, 31'($urandom)};
            2: den = 32'd1 << $urandom_range(31);
            3: den = '1;
            4: den = $urandom_range(16'hffff, 1);
            default: den = $urandom;
        endcase
        case ($urandom_range(5))
            0: lo = '0;
            1: lo = '1;
            default: lo = $urandom;
        endcase
        kind = $urandom_range(99);
        if (kind < 4)
        begin
            den = '0;
            hi  = $urandom;
        end
        else if (den == '0)
            hi = $urandom;
        else if (kind < 7)
            hi = den;
        else if (kind < 13)
            hi = $urandom_range(32'hffffffff, den);
        else if (kind < 20)
            hi = den - 1;
        else
            hi = $urandom_range(den - 1, 0);
        send_division({hi, lo}, den);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_chance, input int count);
        send_idle_pct = idle_pct;
        stall_pct     = stall_chance;
        repeat (count)
            send_random_division();
        drain_divider();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_division(64'd0, 32'd0);
        send_division('1, 32'd0);
        send_division(64'd0, 32'd1);
        send_division(64'h0000_0000_ffff_ffff, 32'd1);
        send_division(64'h0000_0001_0000_0000, 32'd1);
        send_division(64'h0000_0000_ffff_ffff, 32'hffff_ffff);
        send_division(64'hffff_fffe_ffff_ffff, 32'hffff_ffff);
        send_division(64'hffff_ffff_0000_0000, 32'hffff_ffff);
        send_division('1, 32'hffff_ffff);
        send_division(64'h7fff_ffff_ffff_ffff, 32'h8000_0000);
        send_division(64'h8000_0000_0000_0000, 32'h8000_0000);
        send_division(64'h8000_0000_0000_0000, 32'h8000_0001);
        send_division(64'h8000_0000_ffff_ffff, 32'hc000_0000);
        send_division(64'd100, 32'd7);
        send_division(64'd1, 32'd2);
        send_division(64'd0, 32'hffff_ffff);
        send_division(64'h0000_0003_1234_5678, 32'd5);
        send_division(64'h0000_0004_0000_0000, 32'd4);
        send_division(64'h5555_5555_aaaa_aaaa, 32'haaaa_aaab);
        send_division(64'haaaa_aaaa_5555_5555, 32'haaaa_aaaa);
        directed = sent;
        drain_divider();

        run_phase(0, 0, 450);
        run_phase(88, 0, 450);
        run_phase(0, 88, 450);
        run_phase(14, 14, 450);

        stall_pct = 0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("sent %0d divisions (%0d directed) through four flow-control phases",
                 sent, directed);
        $display("checked %0d results: %0d divide by zero, %0d overflow",
                 checked, zero_divides, overflows);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #(8 * 200000);
        $display("status: fail");
        $finish;
    end

endmodule
